@@ hw/rtl/ddo_pkg.sv @@
// shared constants, types and tables for the odometry block
package ddo_pkg;

	localparam int unsigned CordicStepsDef = 24;
	localparam logic [31:0] DistPerCountRst = 32'd2820768;
	localparam logic [31:0] TurnPerMeterRst = 32'd1619822759;
	localparam logic [31:0] InvGain = 32'h9B74EDA8;
	localparam logic [19:0] UsPerS = 20'd1000000;

	// configuration register indexes
	localparam logic CfgDistPerCount = 1'b0;
	localparam logic CfgTurnPerMeter = 1'b1;

	// datapath operations
	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_DIST_L,
		OP_DIST_R,
		OP_ROT,
		OP_GAIN_HI,
		OP_GAIN_LO,
		OP_CORDIC,
		OP_POSE,
		OP_DIV_START,
		OP_DIV_STEP,
		OP_DIV_DONE
	} ddo_op_t;

	typedef struct packed {
		ddo_op_t    op;
		logic [1:0] sel;
	} ddo_cmd_t;

	typedef struct packed {
		logic zero_dt;
	} ddo_stat_t;

	function automatic logic [31:0] atan_of(input logic [4:0] i);
		logic [31:0] r;
		begin
			case (i)
				5'd0: r = 32'd536870912;  5'd1: r = 32'd316933406;
				5'd2: r = 32'd167458907;  5'd3: r = 32'd85004756;
				5'd4: r = 32'd42667331;   5'd5: r = 32'd21354465;
				5'd6: r = 32'd10679838;   5'd7: r = 32'd5340245;
				5'd8: r = 32'd2670163;    5'd9: r = 32'd1335087;
				5'd10: r = 32'd667544;    5'd11: r = 32'd333772;
				5'd12: r = 32'd166886;    5'd13: r = 32'd83443;
				5'd14: r = 32'd41722;     5'd15: r = 32'd20861;
				5'd16: r = 32'd10430;     5'd17: r = 32'd5215;
				5'd18: r = 32'd2608;      5'd19: r = 32'd1304;
				5'd20: r = 32'd652;       5'd21: r = 32'd326;
				5'd22: r = 32'd163;       5'd23: r = 32'd81;
				5'd24: r = 32'd41;        5'd25: r = 32'd20;
				5'd26: r = 32'd10;        5'd27: r = 32'd5;
				5'd28: r = 32'd3;         5'd29: r = 32'd1;
				5'd30: r = 32'd1;         default: r = 32'd0;
			endcase
			return r;
		end
	endfunction

endpackage

@@ hw/rtl/ddo_ctrl.sv @@
// sequencer that steps the odometry datapath through one tick
module ddo_ctrl #(
	parameter int unsigned CORDIC_STEPS = ddo_pkg::CordicStepsDef
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  logic               out_ready,
	input  ddo_pkg::ddo_stat_t stat,
	output ddo_pkg::ddo_cmd_t  cmd
);
	import ddo_pkg::*;

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_DL    = 4'd1;
	localparam logic [3:0] S_DR    = 4'd2;
	localparam logic [3:0] S_ROT   = 4'd3;
	localparam logic [3:0] S_GH    = 4'd4;
	localparam logic [3:0] S_GL    = 4'd5;
	localparam logic [3:0] S_COR   = 4'd6;
	localparam logic [3:0] S_POSE  = 4'd7;
	localparam logic [3:0] S_DST   = 4'd8;
	localparam logic [3:0] S_DSTEP = 4'd9;
	localparam logic [3:0] S_DDONE = 4'd10;
	localparam logic [3:0] S_OUT   = 4'd11;

	localparam int CntW = 6;

	logic [3:0]      state_q;
	logic [CntW-1:0] cnt_q;
	logic [1:0]      div_q;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = (state_q == S_OUT);

	// command decode
	always_comb begin
		cmd.sel = div_q;
		unique case (state_q)
			S_IDLE:  cmd.op = (in_valid) ? OP_LOAD : OP_NONE;
			S_DL:    cmd.op = OP_DIST_L;
			S_DR:    cmd.op = OP_DIST_R;
			S_ROT:   cmd.op = OP_ROT;
			S_GH:    cmd.op = OP_GAIN_HI;
			S_GL:    cmd.op = OP_GAIN_LO;
			S_COR:   cmd.op = OP_CORDIC;
			S_POSE:  cmd.op = OP_POSE;
			S_DST:   cmd.op = OP_DIV_START;
			S_DSTEP: cmd.op = OP_DIV_STEP;
			S_DDONE: cmd.op = OP_DIV_DONE;
			default: cmd.op = OP_NONE;
		endcase
	end

	// state sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			div_q   <= '0;
		end else begin
			unique case (state_q)
				S_IDLE:  if (in_valid) state_q <= S_DL;
				S_DL:    state_q <= S_DR;
				S_DR:    state_q <= S_ROT;
				S_ROT:   state_q <= S_GH;
				S_GH:    state_q <= S_GL;
				S_GL: begin
					state_q <= S_COR;
					cnt_q   <= '0;
				end
				S_COR: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CntW'(CORDIC_STEPS - 1)) state_q <= S_POSE;
				end
				S_POSE: begin
					div_q <= '0;
					state_q <= stat.zero_dt ? S_OUT : S_DST;
				end
				S_DST: begin
					cnt_q   <= '0;
					state_q <= S_DSTEP;
				end
				S_DSTEP: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CntW'(32)) state_q <= S_DDONE;
				end
				S_DDONE: begin
					div_q   <= div_q + 1'b1;
					state_q <= (div_q == 2'd2) ? S_OUT : S_DST;
				end
				S_OUT:   if (out_ready) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

@@ hw/rtl/ddo_dp.sv @@
// odometry datapath: distances, rotation, cordic, pose and rate divider
module ddo_dp #(
	parameter int unsigned CORDIC_STEPS = ddo_pkg::CordicStepsDef
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [0:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	input  logic signed [31:0] left_count,
	input  logic signed [31:0] right_count,
	input  logic [23:0]        elapsed_us,
	input  ddo_pkg::ddo_cmd_t  cmd,
	output ddo_pkg::ddo_stat_t stat,
	output logic signed [31:0] pos_x,
	output logic signed [31:0] pos_y,
	output logic [31:0]        heading,
	output logic signed [31:0] vel_x,
	output logic signed [31:0] vel_y,
	output logic signed [31:0] yaw_rate,
	output logic               zero_time
);
	import ddo_pkg::*;

	logic [31:0] dpc_q, tpm_q;
	logic [31:0] lprev_q, rprev_q, x_q, y_q, hd_q;
	logic [31:0] lc_q, rc_q;
	logic [23:0] dt_q;
	logic signed [63:0] dl_q, dr_q;
	logic [31:0] rot_q;
	logic [31:0] mid_q;
	logic [47:0] mag_q;
	logic        neg_q;
	logic [47:0] gacc_q;
	logic signed [63:0] cx_q, cy_q, cz_q;
	logic [4:0]  it_q;
	// divider
	logic [32:0] dnum_q;
	logic [56:0] rem_q;
	logic [32:0] quo_q;
	logic [39:0] dden_q;
	logic        dneg_q;
	logic        dovf_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dpc_q <= DistPerCountRst;
			tpm_q <= TurnPerMeterRst;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CfgDistPerCount: dpc_q <= cfg_data;
				CfgTurnPerMeter: tpm_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// shared 33x33 signed multiplier for the scaling steps
	logic signed [32:0] ma, mb;
	logic signed [65:0] mp;
	logic [63:0] step64;
	assign step64 = 64'((dl_q + dr_q) >>> 1);

	always_comb begin
		ma = '0;
		mb = '0;
		case (cmd.op)
			OP_DIST_L: begin
				ma = 33'(signed'(32'(lc_q - lprev_q)));
				mb = {1'b0, dpc_q};
			end
			OP_DIST_R: begin
				ma = 33'(signed'(32'(rc_q - rprev_q)));
				mb = {1'b0, dpc_q};
			end
			OP_GAIN_HI: begin
				ma = {17'd0, mag_q[47:32]};
				mb = {1'b0, InvGain};
			end
			OP_GAIN_LO: begin
				ma = {1'b0, mag_q[31:0]};
				mb = {1'b0, InvGain};
			end
			default: ;
		endcase
		mp = ma * mb;
	end

	// rotation: low 48 bits of (dl-dr)*tpm, split over two partial products
	logic [47:0] dd48;
	logic [47:0] rot_lo, rot_hi;
	logic [31:0] rot_w;
	assign dd48   = 48'(dl_q - dr_q);
	assign rot_lo = 48'({16'd0, dd48[23:0]} * {16'd0, tpm_q});
	assign rot_hi = 48'({24'd0, dd48[47:24]} * {16'd0, tpm_q});
	assign rot_w  = 32'((rot_lo + {rot_hi[23:0], 24'd0}) >> 16);

	// cordic iteration
	logic signed [63:0] xs, ys;
	assign xs = cx_q >>> it_q;
	assign ys = cy_q >>> it_q;

	// divider step: restoring, one quotient bit per cycle
	logic [56:0] rem_sh;
	logic [57:0] rem_sub;
	assign rem_sh  = {rem_q[55:0], dnum_q[32]};
	assign rem_sub = {1'b0, rem_sh} - {18'd0, dden_q};

	logic signed [63:0] num_sel;
	always_comb begin
		case (cmd.sel)
			2'd0:    num_sel = cx_q;
			2'd1:    num_sel = cy_q;
			default: num_sel = 64'(signed'(rot_q));
		endcase
	end
	logic [63:0] num_mag;
	assign num_mag = num_sel[63] ? 64'(-num_sel) : 64'(num_sel);

	// dividend is the clipped magnitude times 10^6; quotient of 2^33 or more saturates
	logic [36:0] num_clip;
	logic [56:0] num_us;
	logic [39:0] dden_w;
	logic        ovf_w;
	assign num_clip = (num_mag >= 64'h1000000000) ? 37'h1FFFFFFFFF : 37'(num_mag);
	assign num_us   = {20'd0, num_clip} * {37'd0, UsPerS};
	assign dden_w   = (cmd.sel == 2'd2) ? {dt_q, 16'd0} : {16'd0, dt_q};
	assign ovf_w    = ({16'd0, num_us[56:33]} >= dden_w);

	// rate result: saturate then sign
	logic [32:0] quo_sat;
	logic [31:0] rate_w;
	assign quo_sat = dovf_q ? 33'h1FFFFFFFF : quo_q;
	always_comb begin
		if (!dneg_q)
			rate_w = (quo_sat > 33'h7FFFFFFF) ? 32'h7FFFFFFF : quo_sat[31:0];
		else if (quo_sat >= 33'h80000000)
			rate_w = 32'h80000000;
		else
			rate_w = 32'(-quo_sat[31:0]);
	end

	assign stat.zero_dt = (dt_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lprev_q <= '0;
			rprev_q <= '0;
			x_q     <= '0;
			y_q     <= '0;
			hd_q    <= '0;
		end else begin
			case (cmd.op)
				OP_POSE: begin
					lprev_q <= lc_q;
					rprev_q <= rc_q;
					x_q     <= x_q + cx_q[31:0];
					y_q     <= y_q + cy_q[31:0];
					hd_q    <= hd_q + rot_q;
				end
				default: ;
			endcase
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD: begin
				lc_q <= left_count;
				rc_q <= right_count;
				dt_q <= elapsed_us;
			end
			OP_DIST_L: dl_q <= 64'(mp >>> 16);
			OP_DIST_R: dr_q <= 64'(mp >>> 16);
			OP_ROT: begin
				rot_q <= rot_w;
				mid_q <= hd_q + 32'(signed'(rot_w) >>> 1);
				neg_q <= step64[63];
				mag_q <= step64[63] ? 48'(-step64) : step64[47:0];
			end
			OP_GAIN_HI: gacc_q <= 48'(mp);
			OP_GAIN_LO: begin
				// (hi*c + (lo*c>>32)), applied with sign; pre-rotate on left half plane
				cx_q  <= (neg_q ^ ((mid_q + 32'h40000000) >= 32'h80000000)) ?
					-64'(gacc_q + 48'(mp >> 32)) : 64'(gacc_q + 48'(mp >> 32));
				cy_q  <= '0;
				cz_q  <= 64'(signed'(((mid_q + 32'h40000000) >= 32'h80000000) ?
					32'(mid_q - 32'h80000000) : mid_q));
				it_q  <= '0;
			end
			OP_CORDIC: begin
				if (!cz_q[63]) begin
					cx_q <= cx_q - ys;
					cy_q <= cy_q + xs;
					cz_q <= cz_q - 64'(atan_of(it_q));
				end else begin
					cx_q <= cx_q + ys;
					cy_q <= cy_q - xs;
					cz_q <= cz_q + 64'(atan_of(it_q));
				end
				it_q <= it_q + 1'b1;
			end
			OP_POSE: begin
				pos_x     <= x_q + cx_q[31:0];
				pos_y     <= y_q + cy_q[31:0];
				heading   <= hd_q + rot_q;
				zero_time <= (dt_q == '0);
				vel_x     <= '0;
				vel_y     <= '0;
				yaw_rate  <= '0;
			end
			OP_DIV_START: begin
				dneg_q <= num_sel[63];
				dovf_q <= ovf_w;
				dnum_q <= num_us[32:0];
				dden_q <= dden_w;
				rem_q  <= {33'd0, num_us[56:33]};
				quo_q  <= '0;
			end
			OP_DIV_STEP: begin
				// shift in the next dividend bit
				dnum_q <= {dnum_q[31:0], 1'b0};
				if (!rem_sub[57]) begin
					rem_q <= rem_sub[56:0];
				end else begin
					rem_q <= rem_sh;
				end
				quo_q <= {quo_q[31:0], !rem_sub[57]};
			end
			OP_DIV_DONE: begin
				case (cmd.sel)
					2'd0:    vel_x    <= rate_w;
					2'd1:    vel_y    <= rate_w;
					default: yaw_rate <= rate_w;
				endcase
			end
			default: ;
		endcase
	end

endmodule

@@ hw/rtl/diff_drive_odometry.sv @@
// differential drive odometry: one pose and velocity result per tick
// steps: load, distances, rotation, gain, cordic, pose, three rate divisions if dt > 0
// ticks are handled one at a time: in_ready returns only after the result is taken
// the cordic iterations and the bit-serial rate divider take most of each tick
// reset: previous counts, pose and heading clear to zero, registers to defaults
module diff_drive_odometry #(
	parameter int unsigned CORDIC_STEPS = ddo_pkg::CordicStepsDef
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [0:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [31:0] left_count,
	input  logic signed [31:0] right_count,
	input  logic [23:0]        elapsed_us,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] pos_x,
	output logic signed [31:0] pos_y,
	output logic [31:0]        heading,
	output logic signed [31:0] vel_x,
	output logic signed [31:0] vel_y,
	output logic signed [31:0] yaw_rate,
	output logic               zero_time
);
	import ddo_pkg::*;

	ddo_cmd_t  cmd;
	ddo_stat_t stat;

	// sequencer
	ddo_ctrl #(.CORDIC_STEPS(CORDIC_STEPS)) u_ctrl (
		.clk, .arst_n, .in_valid, .in_ready, .out_valid, .out_ready,
		.stat, .cmd
	);

	// datapath
	ddo_dp #(.CORDIC_STEPS(CORDIC_STEPS)) u_dp (
		.clk, .arst_n, .cfg_we, .cfg_index, .cfg_data,
		.left_count, .right_count, .elapsed_us, .cmd, .stat,
		.pos_x, .pos_y, .heading, .vel_x, .vel_y, .yaw_rate, .zero_time
	);

`ifndef SYNTHESIS
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid)) else $error("ready while result pending");
	a_zero_vel: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && zero_time) |-> (vel_x == 0 && vel_y == 0 && yaw_rate == 0))
		else $error("velocity not zero on zero time");
	a_out_after: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready) |=> in_ready) else $error("no return to idle");
`endif

endmodule

@@ bench/ddo_checker.sv @@
// checker: predicts odometry results per accepted tick and compares them
`timescale 1ns / 100ps
module ddo_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [0:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	input  logic               in_valid,
	input  logic               in_ready,
	input  logic signed [31:0] left_count,
	input  logic signed [31:0] right_count,
	input  logic [23:0]        elapsed_us,
	input  logic               out_valid,
	input  logic               out_ready,
	input  logic signed [31:0] pos_x,
	input  logic signed [31:0] pos_y,
	input  logic [31:0]        heading,
	input  logic signed [31:0] vel_x,
	input  logic signed [31:0] vel_y,
	input  logic signed [31:0] yaw_rate,
	input  logic               zero_time,
	output int                 errors,
	output int                 pending
);
	import ddo_pkg::*;

	typedef struct packed {
		logic [31:0] px, py, hd, vx, vy, yr;
		logic        zt;
	} pose_t;

	pose_t       pose_q[$];
	logic [31:0] m_dpc, m_tpm, m_lprev, m_rprev, m_x, m_y, m_hd;

	localparam logic [31:0] AtanTab [32] = '{
		536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
		10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
		83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163,
		81, 41, 20, 10, 5, 3, 1, 1, 0};

	assign pending = pose_q.size();

	// v * c / 2^32 truncated toward zero
	function automatic longint scale_q32(longint v, logic [31:0] c);
		logic [63:0] m, r;
		m = (v < 0) ? -v : v;
		r = (m >> 32) * c + (((m & 64'hFFFFFFFF) * c) >> 32);
		return (v < 0) ? -longint'(r) : longint'(r);
	endfunction

	// num * 1e6 / den, truncated, clamped to int32
	function automatic logic [31:0] rate_of(longint num, logic [63:0] den);
		logic [63:0] m, q;
		m = (num < 0) ? -num : num;
		if (m >= (64'd1 << 36)) q = 64'd1 << 32;
		else q = m * 64'd1000000 / den;
		if (num >= 0) return (q > 64'h7FFFFFFF) ? 32'h7FFFFFFF : q[31:0];
		if (q > 64'h80000000) q = 64'h80000000;
		return -q[31:0];
	endfunction

	function automatic pose_t predict_pose(logic [31:0] lc, logic [31:0] rc,
			logic [23:0] dt);
		longint dl, dr, stp, rs, x, y, z, xs, ys;
		logic [31:0] rot, mid, dlc, drc;
		logic [63:0] prod;
		pose_t p;
		dlc = lc - m_lprev;
		drc = rc - m_rprev;
		dl = (longint'($signed(dlc)) * longint'({32'd0, m_dpc})) >>> 16;
		dr = (longint'($signed(drc)) * longint'({32'd0, m_dpc})) >>> 16;
		stp = (dl + dr) >>> 1;
		prod = 64'(dl - dr) * {32'd0, m_tpm};
		rot = prod[47:16];
		rs = longint'($signed(rot));
		mid = m_hd + 32'(rs >>> 1);
		m_lprev = lc;
		m_rprev = rc;
		// cordic rotation with left half plane pre-rotation
		x = scale_q32(stp, InvGain);
		y = 0;
		if (((mid + 32'h40000000) & 32'h80000000) != 0) begin
			x = -x;
			mid = mid - 32'h80000000;
		end
		z = longint'($signed(mid));
		for (int i = 0; i < CordicStepsDef; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (z >= 0) begin
				x -= ys; y += xs; z -= longint'({32'd0, AtanTab[i]});
			end else begin
				x += ys; y -= xs; z += longint'({32'd0, AtanTab[i]});
			end
		end
		m_x = m_x + x[31:0];
		m_y = m_y + y[31:0];
		m_hd = m_hd + rot;
		p.px = m_x; p.py = m_y; p.hd = m_hd;
		if (dt == 0) begin
			p.vx = 0; p.vy = 0; p.yr = 0; p.zt = 1'b1;
		end else begin
			p.vx = rate_of(x, {40'd0, dt});
			p.vy = rate_of(y, {40'd0, dt});
			p.yr = rate_of(rs, {24'd0, dt, 16'd0});
			p.zt = 1'b0;
		end
		return p;
	endfunction

	// watch config, input and output transfers
	always @(posedge clk or negedge arst_n) begin
		pose_t e, a;
		if (!arst_n) begin
			m_dpc = DistPerCountRst; m_tpm = TurnPerMeterRst;
			m_lprev = 0; m_rprev = 0; m_x = 0; m_y = 0; m_hd = 0;
			pose_q.delete();
			errors = 0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == CfgDistPerCount) m_dpc = cfg_data;
				else m_tpm = cfg_data;
			end
			if (out_valid && out_ready) begin
				a = '{pos_x, pos_y, heading, vel_x, vel_y, yaw_rate, zero_time};
				if (pose_q.size() == 0) begin
					$display("%0t: unexpected result %h", $time, a);
					errors++;
				end else begin
					e = pose_q.pop_front();
					if (e != a) begin
						$display("%0t: mismatch expected x=%h y=%h h=%h vx=%h vy=%h yr=%h z=%b",
							$time, e.px, e.py, e.hd, e.vx, e.vy, e.yr, e.zt);
						$display("%0t:          actual   x=%h y=%h h=%h vx=%h vy=%h yr=%h z=%b",
							$time, a.px, a.py, a.hd, a.vx, a.vy, a.yr, a.zt);
						errors++;
					end
				end
			end
			if (in_valid && in_ready)
				pose_q.push_back(predict_pose(left_count, right_count, elapsed_us));
		end
	end
endmodule

@@ bench/tb.sv @@
// top of the odometry testbench: stimulus, config phases and verdict
`timescale 1ns / 100ps
module tb;
	import ddo_pkg::*;

	logic               clk = 0, arst_n = 0;
	logic               cfg_we = 0;
	logic [0:0]         cfg_index = CfgDistPerCount;
	logic [31:0]        cfg_data = 0;
	logic               in_valid = 0, in_ready;
	logic signed [31:0] left_count = 0, right_count = 0;
	logic [23:0]        elapsed_us = 0;
	logic               out_valid, out_ready = 0;
	logic signed [31:0] pos_x, pos_y, vel_x, vel_y, yaw_rate;
	logic [31:0]        heading;
	logic               zero_time;
	int                 errors, pending;
	bit                 calm = 0, hold = 0;
	logic [31:0]        lc_cur = 0, rc_cur = 0;

	always #10 clk = ~clk;

	diff_drive_odometry DUT (.*);
	ddo_checker chk (.*);

	// receiver: random stalls, a long hold-off when asked
	always @(negedge clk) out_ready <= hold ? 1'b0 : (calm || $urandom_range(99) >= 8);

	task automatic send_tick(logic [31:0] l, logic [31:0] r, logic [23:0] dt);
		@(negedge clk);
		while (!calm && $urandom_range(99) < 8) @(negedge clk);
		in_valid <= 1; left_count <= l; right_count <= r; elapsed_us <= dt;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		@(negedge clk);
		in_valid <= 0;
	endtask

	task automatic write_reg(logic [0:0] idx, logic [31:0] v);
		while (pending != 0) @(negedge clk);
		repeat (400) @(negedge clk);
		cfg_we <= 1; cfg_index <= idx; cfg_data <= v;
		@(negedge clk);
		cfg_we <= 0;
	endtask

	// well-formed motion: small count deltas, sometimes big jumps
	task automatic motion_tick();
		int k;
		k = $urandom_range(99);
		if (k < 80) begin
			lc_cur += $signed($urandom_range(4000)) - 2000;
			rc_cur += $signed($urandom_range(4000)) - 2000;
		end else begin
			lc_cur = $urandom; rc_cur = $urandom;
		end
		k = $urandom_range(99);
		send_tick(lc_cur, rc_cur, k < 5 ? 24'd0 : k < 10 ? 24'($urandom) :
			k < 15 ? 24'd1 : 24'($urandom_range(100000, 1000)));
	endtask

	initial begin
		#400000000;
		$display("DONE: errors detected");
		$finish;
	end

	initial begin
		logic [31:0] dv [4];
		logic [31:0] tv [4];
		dv = '{32'd2820768, 32'hFFFFFFFF, 32'd1, 32'd0};
		tv = '{32'd1619822759, 32'd1, 32'hFFFFFFFF, 32'd0};
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		// directed: first tick full counts, extremes, zero time, big turns
		send_tick(32'd1000, 32'd1000, 24'd0);
		send_tick(32'h7FFFFFFF, 32'h80000000, 24'hFFFFFF);
		send_tick(32'h80000000, 32'h7FFFFFFF, 24'd1);
		send_tick(32'hFFFFFFFF, 32'h00000000, 24'd1);
		send_tick(32'h0, 32'hFFFFFFFF, 24'd0);
		send_tick(32'd5000, 32'd5000, 24'd20000);
		send_tick(32'd4000, 32'd6000, 24'd20000);
		send_tick(32'h40000000, 32'hC0000000, 24'd50);
		send_tick(32'h0, 32'h0, 24'd1);
		write_reg(CfgDistPerCount, 32'hFFFFFFFF);
		write_reg(CfgTurnPerMeter, 32'hFFFFFFFF);
		send_tick(32'h7FFFFFFF, 32'h80000001, 24'd1);
		send_tick(32'h12345678, 32'h9ABCDEF0, 24'hFFFFFF);
		send_tick(32'h0, 32'h0, 24'd0);
		write_reg(CfgDistPerCount, 32'd0);
		send_tick(32'd99999, 32'd3, 24'd10);
		write_reg(CfgDistPerCount, 32'd2820768);
		write_reg(CfgTurnPerMeter, 32'd0);
		send_tick(32'd100, 32'd900, 24'd10);
		lc_cur = 32'd100; rc_cur = 32'd900;
		// random phases over register settings
		for (int ph = 0; ph < 6; ph++) begin
			if (ph < 4) begin
				write_reg(CfgDistPerCount, dv[ph] == 0 ? 32'd1 : dv[ph]);
				write_reg(CfgTurnPerMeter, tv[ph] == 0 ? 32'd1 : tv[ph]);
			end else begin
				write_reg(CfgDistPerCount, $urandom);
				write_reg(CfgTurnPerMeter, $urandom);
			end
			calm = (ph == 2);
			if (ph == 1) fork
				begin
					hold = 1;
					repeat (3000) @(negedge clk);
					hold = 0;
				end
			join_none
			for (int n = 0; n < 255; n++) begin
				if ($urandom_range(99) < 10)
					send_tick($urandom, $urandom, 24'($urandom));
				else
					motion_tick();
			end
		end
		calm = 0;
		while (pending != 0) @(negedge clk);
		repeat (400) @(negedge clk);
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end
endmodule
